[sv/pli_pkg.sv]
// package: types, constants and codes for the piecewise linear interpolator
package pli_pkg;
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int QDEPTH = 2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] REGION_INSIDE = 2'd0;
    localparam logic [1:0] REGION_LOW = 2'd1;
    localparam logic [1:0] REGION_HIGH = 2'd2;

    typedef struct packed {
        logic action;
        logic [3:0] entry_index;
        logic [31:0] entry_key;
        logic signed [31:0] entry_value;
        logic [31:0] query_key;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] interpolated_value;
        logic [1:0] region;
    } out_item_t;

    // query with its last table index, handed from front to back
    typedef struct packed {
        logic [31:0] key;
        logic [IDX_W-1:0] last;
    } query_t;
endpackage

[sv/pli_front.sv]
// front: accepts items, applies loads, queues queries with their last table index
module pli_front (
    input logic aclk,
    input logic aresetn,
    input logic cfg_wr_en,
    input logic [4:0] cfg_wr_data,
    input logic s_valid,
    output logic s_ready,
    input pli_pkg::in_item_t s_data,
    output logic q_valid,
    input logic q_ready,
    output pli_pkg::query_t q_data,
    output logic ld_en,
    output logic [pli_pkg::IDX_W-1:0] ld_idx,
    output logic [31:0] ld_key,
    output logic [31:0] ld_val
);
    import pli_pkg::*;

    logic [4:0] used_reg;
    query_t fifo_reg [QDEPTH];
    logic rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic push, pop;
    logic [IDX_W-1:0] last;

    always_comb begin
        if (used_reg == 5'd0) begin
            last = '0;
        end else if (32'(used_reg) > TABLE_DEPTH) begin
            last = IDX_W'(TABLE_DEPTH - 1);
        end else begin
            last = IDX_W'(used_reg - 5'd1);
        end
    end

    // a load waits until no query is queued or in the back end
    assign s_ready = (s_data.action == ACT_LOAD) ? ((cnt_reg == 2'd0) && q_ready)
                                                 : (cnt_reg != 2'(QDEPTH));
    assign push = s_valid && s_ready && (s_data.action == ACT_QUERY);
    assign pop = q_valid && q_ready;
    assign q_valid = cnt_reg != 2'd0;
    assign q_data = fifo_reg[rd_ptr_reg];

    assign ld_en = s_valid && s_ready && (s_data.action == ACT_LOAD)
                   && (32'(s_data.entry_index) < TABLE_DEPTH);
    assign ld_idx = IDX_W'(s_data.entry_index);
    assign ld_key = s_data.entry_key;
    assign ld_val = s_data.entry_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 5'd1;
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                used_reg <= cfg_wr_data;
            end
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= '{key: s_data.query_key, last: last};
        end
    end
endmodule

[sv/pli_div.sv]
// divider: 64 by 32 unsigned restoring division, one bit a cycle
module pli_div (
    input logic aclk,
    input logic aresetn,
    input logic start,
    input logic [63:0] dividend,
    input logic [31:0] divisor,
    output logic done,
    output logic [63:0] quotient
);
    import pli_pkg::*;

    logic [63:0] q_reg;
    logic [32:0] rem_reg;
    logic [31:0] den_reg;
    logic [6:0] cnt_reg;
    logic busy_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg[31:0], q_reg[63]};
    assign diff = shifted - {1'b0, den_reg};
    assign done = busy_reg && (cnt_reg == 7'd0);
    assign quotient = q_reg;

    // done and the quotient hold until the next start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= 7'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= 7'd64;
        end else if (busy_reg && cnt_reg != 7'd0) begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg && cnt_reg != 7'd0) begin
            if (!diff[32]) begin
                rem_reg <= diff;
                q_reg <= {q_reg[62:0], 1'b1};
            end else begin
                rem_reg <= shifted;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end
endmodule

[sv/pli_back.sv]
// back: table storage, bracket scan, interpolation and output register
module pli_back (
    input logic aclk,
    input logic aresetn,
    input logic ld_en,
    input logic [pli_pkg::IDX_W-1:0] ld_idx,
    input logic [31:0] ld_key,
    input logic [31:0] ld_val,
    input logic q_valid,
    output logic q_ready,
    input pli_pkg::query_t q_data,
    output logic m_valid,
    input logic m_ready,
    output pli_pkg::out_item_t m_data
);
    import pli_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_RD0 = 7'b0000010,
        ST_RDL = 7'b0000100,
        ST_CHK = 7'b0001000,
        ST_SCAN = 7'b0010000,
        ST_MUL = 7'b0100000,
        ST_DIV = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] key_mem [TABLE_DEPTH];
    logic [31:0] val_mem [TABLE_DEPTH];
    logic [IDX_W-1:0] rd_addr;
    logic [31:0] rk_reg, rv_reg;
    logic [31:0] k0_reg, v0_reg, kl_reg, vl_reg;
    logic [31:0] k1_reg, v1_reg;
    logic [31:0] key_reg;
    logic [IDX_W-1:0] last_reg, i_reg;
    logic first_reg;
    logic [31:0] mag_reg, num_reg, den_reg;
    logic neg_reg;
    logic [63:0] prod;
    logic div_start;
    logic div_done;
    logic [63:0] div_q;
    logic out_valid_reg;
    out_item_t out_reg;
    logic [32:0] diff;
    logic [31:0] sum;
    logic out_free;
    logic out_load;
    logic scan_step;
    out_item_t out_next;

    pli_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(prod), .divisor(den_reg),
        .done(div_done), .quotient(div_q)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;
    assign q_ready = (state_reg == ST_IDLE);
    assign diff = {rv_reg[31], rv_reg} - {v1_reg[31], v1_reg};
    assign sum = neg_reg ? v1_reg - div_q[31:0] : v1_reg + div_q[31:0];
    assign prod = 64'(mag_reg) * 64'(num_reg);
    assign scan_step = (first_reg || !(key_reg >= k1_reg && key_reg <= rk_reg))
                       && (i_reg != last_reg);

    always_comb begin
        case (state_reg)
            ST_IDLE: rd_addr = '0;
            ST_RD0: rd_addr = last_reg;
            ST_SCAN: rd_addr = scan_step ? i_reg + 1'b1 : i_reg;
            default: rd_addr = i_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ld_en) begin
            key_mem[ld_idx] <= ld_key;
            val_mem[ld_idx] <= ld_val;
        end
        rk_reg <= key_mem[rd_addr];
        rv_reg <= val_mem[rd_addr];
    end

    always_comb begin
        state_next = state_reg;
        out_load = 1'b0;
        out_next = out_reg;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_RD0;
                end
            end
            ST_RD0: state_next = ST_RDL;
            ST_RDL: state_next = ST_CHK;
            ST_CHK: begin
                if (key_reg <= k0_reg || key_reg >= kl_reg) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        out_next.interpolated_value = (key_reg <= k0_reg) ? v0_reg : vl_reg;
                        out_next.region = (key_reg <= k0_reg) ? REGION_LOW : REGION_HIGH;
                        state_next = ST_IDLE;
                    end
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!first_reg && key_reg >= k1_reg && key_reg <= rk_reg) begin
                    if (rk_reg == k1_reg) begin
                        if (out_free) begin
                            out_load = 1'b1;
                            out_next.interpolated_value = v1_reg;
                            out_next.region = REGION_INSIDE;
                            state_next = ST_IDLE;
                        end
                    end else begin
                        state_next = ST_MUL;
                    end
                end else if (!first_reg && i_reg == last_reg) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        out_next.interpolated_value = vl_reg;
                        out_next.region = REGION_HIGH;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MUL: begin
                div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        out_next.interpolated_value = sum;
                        out_next.region = REGION_INSIDE;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_DIV;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // divider quotient holds after done, so waiting on a stalled output is safe
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= out_next;
        end
        case (state_reg)
            ST_IDLE: begin
                key_reg <= q_data.key;
                last_reg <= q_data.last;
                i_reg <= '0;
            end
            ST_RD0: begin
                k0_reg <= rk_reg;
                v0_reg <= rv_reg;
            end
            ST_RDL: begin
                kl_reg <= rk_reg;
                vl_reg <= rv_reg;
            end
            ST_CHK: begin
                first_reg <= 1'b1;
            end
            ST_SCAN: begin
                if (first_reg || !(key_reg >= k1_reg && key_reg <= rk_reg)) begin
                    if (i_reg != last_reg) begin
                        k1_reg <= rk_reg;
                        v1_reg <= rv_reg;
                        first_reg <= 1'b0;
                        i_reg <= i_reg + 1'b1;
                    end
                end else begin
                    neg_reg <= diff[32];
                    mag_reg <= diff[32] ? 32'(-diff) : diff[31:0];
                    num_reg <= key_reg - k1_reg;
                    den_reg <= rk_reg - k1_reg;
                end
            end
            default: ;
        endcase
    end
endmodule

[sv/piecewise_linear_interpolator.sv]
// top level: piecewise linear interpolator over a breakpoint table
//  channel  | ports              | carries
//  input    | s_valid/s_ready    | in_item_t load or query
//  result   | m_valid/m_ready    | out_item_t, one per query
//  config   | cfg_wr_en          | entries_used
// a load is taken once the queue and the back end are empty
// a clamped query passes the queue and states RD0, RDL and CHK; one bracketed at
// entry k also scans the entries up to k in SCAN, and goes through MUL and DIV when
// it interpolates, using the multiply and the one-bit-a-cycle 64/32 divider
// up to two queries wait in the queue; a stalled result holds the back end
// synchronous active-low reset clears control; table contents are kept
module piecewise_linear_interpolator (
    input logic aclk,
    input logic aresetn,
    input logic cfg_wr_en,
    input logic [4:0] cfg_wr_data,
    input logic s_valid,
    output logic s_ready,
    input pli_pkg::in_item_t s_data,
    output logic m_valid,
    input logic m_ready,
    output pli_pkg::out_item_t m_data
);
    import pli_pkg::*;

    logic q_valid, q_ready, ld_en;
    query_t q_data;
    logic [IDX_W-1:0] ld_idx;
    logic [31:0] ld_key, ld_val;

    pli_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .ld_en(ld_en), .ld_idx(ld_idx), .ld_key(ld_key), .ld_val(ld_val)
    );

    pli_back u_back (
        .aclk(aclk), .aresetn(aresetn), .ld_en(ld_en), .ld_idx(ld_idx),
        .ld_key(ld_key), .ld_val(ld_val), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

[sv/pli_checker.sv]
// checker: port-level properties of the interpolator, bound to the top level
module pli_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input pli_pkg::out_item_t m_data
);
    import pli_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
    a_region_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.region == REGION_INSIDE || m_data.region == REGION_LOW
                     || m_data.region == REGION_HIGH))
        else $error("bad region code");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled transaction changed");
    a_quiet_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid at reset release");
endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

[tb/tb_top.sv]
// testbench for the piecewise linear interpolator: directed and random loads and queries
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pli_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 200;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [4:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;

    logic [31:0] bp_key [TABLE_DEPTH];
    logic [31:0] bp_value [TABLE_DEPTH];
    logic [4:0] active_entries;
    out_item_t pending_results [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int queries_sent = 0;
    int loads_sent = 0;
    int quiet_cycles = 0;

    piecewise_linear_interpolator i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int table_size();
        int n;
        n = active_entries;
        if (n == 0) n = 1;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        return n;
    endfunction

    function automatic logic [31:0] blend(logic [31:0] r1, logic [31:0] r2,
                                          logic [31:0] num, logic [31:0] den);
        longint a;
        longint diff;
        longint unsigned mag;
        longint unsigned q;
        a = longint'(signed'(r1));
        diff = longint'(signed'(r2)) - a;
        mag = (diff < 0) ? longint'(-diff) : diff;
        q = (mag * longint'({32'd0, num})) / longint'({32'd0, den});
        return (diff < 0) ? 32'(a - longint'(q)) : 32'(a + longint'(q));
    endfunction

    function automatic out_item_t interpolate(logic [31:0] key);
        out_item_t r;
        int n;
        n = table_size();
        if (key <= bp_key[0]) begin
            r.interpolated_value = bp_value[0];
            r.region = REGION_LOW;
        end else if (key >= bp_key[n-1]) begin
            r.interpolated_value = bp_value[n-1];
            r.region = REGION_HIGH;
        end else begin
            r.interpolated_value = bp_value[n-1];
            r.region = REGION_HIGH;
            for (int i = 0; i + 1 < n; i++) begin
                if (key >= bp_key[i] && key <= bp_key[i+1]) begin
                    if (bp_key[i] == bp_key[i+1]) r.interpolated_value = bp_value[i];
                    else r.interpolated_value = blend(bp_value[i], bp_value[i+1],
                                                      key - bp_key[i],
                                                      bp_key[i+1] - bp_key[i]);
                    r.region = REGION_INSIDE;
                    break;
                end
            end
        end
        return r;
    endfunction

    // one transaction on the input channel, prediction at acceptance
    task automatic send_item(in_item_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        if (item.action == ACT_LOAD) begin
            bp_key[item.entry_index] = item.entry_key;
            bp_value[item.entry_index] = item.entry_value;
            loads_sent++;
        end else begin
            pending_results.insert(pending_results.size(), interpolate(item.query_key));
            queries_sent++;
        end
        @(negedge aclk);
    endtask

    task automatic load_entry(int idx, logic [31:0] k, logic [31:0] v);
        in_item_t it;
        it = in_item_t'($urandom());
        it.query_key = $urandom();
        it.action = ACT_LOAD;
        it.entry_index = 4'(idx);
        it.entry_key = k;
        it.entry_value = v;
        send_item(it);
    endtask

    task automatic query_at(logic [31:0] k);
        in_item_t it;
        it.action = ACT_QUERY;
        it.entry_index = 4'($urandom());
        it.entry_key = $urandom();
        it.entry_value = $urandom();
        it.query_key = k;
        send_item(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_entries(logic [4:0] n);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= n;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        active_entries = n;
    endtask

    // fills the first n slots with ascending keys, duplicates allowed
    task automatic fill_table(int n, bit wide);
        logic [31:0] k;
        k = wide ? 32'd0 : $urandom_range(1000);
        for (int i = 0; i < n; i++) begin
            load_entry(i, k, $urandom());
            if (wide) k = k + $urandom_range(32'h0fff_ffff);
            else if ($urandom_range(5) != 0) k = k + $urandom_range(200);
        end
    endtask

    function automatic logic [31:0] pick_key();
        int n;
        int i;
        n = table_size();
        i = $urandom_range(n - 1);
        case ($urandom_range(5))
            0: return $urandom();
            1: return bp_key[i];
            2: return bp_key[i] + $urandom_range(3) - 1;
            default: return bp_key[0] +
                            $urandom_range(int'(bp_key[n-1] - bp_key[0]) & 32'h7fff_ffff);
        endcase
    endfunction

    task automatic test_directed_extremes();
        set_entries(5'd2);
        load_entry(0, 32'd0, 32'h8000_0000);
        load_entry(1, 32'hffff_ffff, 32'h7fff_ffff);
        query_at(32'd0);
        query_at(32'hffff_ffff);
        query_at(32'h8000_0000);
        query_at(32'd1);
        query_at(32'hffff_fffe);
        load_entry(0, 32'd100, 32'h7fff_ffff);
        load_entry(1, 32'd200, 32'h8000_0000);
        query_at(32'd150);
        query_at(32'd101);
        query_at(32'd199);
        // zero-width interval and out-of-order keys
        set_entries(5'd4);
        load_entry(2, 32'd200, 32'h0100_0000);
        load_entry(3, 32'd300, 32'h0200_0000);
        query_at(32'd200);
        load_entry(1, 32'd400, 32'h0000_0005);
        query_at(32'd250);
        query_at(32'd50);
    endtask

    task automatic test_entry_count_limits();
        fill_table(TABLE_DEPTH, 1'b0);
        set_entries(5'd0);
        query_at(bp_key[0]);
        query_at(bp_key[0] + 1);
        set_entries(5'd31);
        for (int i = 0; i < 6; i++) query_at(pick_key());
        set_entries(5'd16);
        for (int i = 0; i < 6; i++) query_at(pick_key());
    endtask

    task automatic test_random_phase(int items);
        int n;
        n = $urandom_range(1, TABLE_DEPTH);
        set_entries((n == TABLE_DEPTH && $urandom_range(1)) ? 5'd31 : 5'(n));
        fill_table(TABLE_DEPTH, $urandom_range(1));
        for (int i = 0; i < items; i++) begin
            case ($urandom_range(19))
                0: load_entry($urandom_range(table_size() - 1), $urandom(), $urandom());
                1: load_entry($urandom_range(TABLE_DEPTH - 1), pick_key(), $urandom());
                default: query_at(pick_key());
            endcase
        end
    endtask

    task automatic test_pause_until_empty();
        query_at(pick_key());
        query_at(pick_key());
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        query_at(pick_key());
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result value=%h region=%0d",
                             m_data.interpolated_value, m_data.region);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected value=%h region=%0d, got value=%h region=%0d",
                                 want.interpolated_value, want.region,
                                 m_data.interpolated_value, m_data.region);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        active_entries = 5'd1;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_extremes();
        test_entry_count_limits();
        test_pause_until_empty();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 68; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 68; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            test_random_phase(85);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        $display("covered %0d loads and %0d queries, %0d results checked",
                 loads_sent, queries_sent, results_checked);
        $display("entry counts from 0 to 31, clamps, zero-width and unordered intervals");
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
